// ===== rtl/look_at_view_matrix_top_assert.svh =====
// Assertion macros used by the look-at view matrix top level.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LAVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LAVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lavm_pkg.sv =====
// Shared types and constants for the look-at view matrix pipeline.
package lavm_pkg;

    localparam int COORD_W    = 32;              // Q16.16 coordinate
    localparam int FRAC_W     = 16;
    localparam int DIFF_W     = COORD_W + 1;     // exact target - eye
    localparam int POS_W      = $clog2(DIFF_W);
    localparam int TARGET_MSB = 29;              // normalised magnitudes sit in [2^29, 2^30)
    localparam int NMAG_W     = TARGET_MSB + 1;
    localparam int SHL_W      = DIFF_W + TARGET_MSB;
    localparam int SQR_W      = 2 * NMAG_W;
    localparam int SUM_W      = SQR_W + 2;
    localparam int LEN_W      = SUM_W / 2;
    localparam int Q_W        = FRAC_W + 1;      // unsigned quotient, at most 1.0
    localparam int UNIT_W     = Q_W + 1;         // signed unit component
    localparam int U_W        = UNIT_W + 2;      // true-up component, some headroom
    localparam int ROW_W      = 2;

    localparam logic [ROW_W-1:0] ROW_LAST = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [UNIT_W-1:0]  t_unit;
    typedef logic signed [U_W-1:0]     t_up;

    localparam t_coord ONE_Q = t_coord'(1) <<< FRAC_W;

endpackage

// ===== rtl/lavm_if.sv =====
// Input and output channel interfaces of the look-at view matrix block.
interface lavm_in_if import lavm_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord eye_x;
    t_coord eye_y;
    t_coord eye_z;
    t_coord target_x;
    t_coord target_y;
    t_coord target_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    output ready);
endinterface

interface lavm_out_if import lavm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_index;
    t_coord           col0;
    t_coord           col1;
    t_coord           col2;
    t_coord           col3;
    logic             degenerate;
    logic             last;

    modport source (output valid, row_index, col0, col1, col2, col3, degenerate, last,
                    input ready);
    modport sink   (input valid, row_index, col0, col1, col2, col3, degenerate, last,
                    output ready);
endinterface

// ===== rtl/lavm_isqrt.sv =====
// Pipelined floor square root, a few result bits per stage.
module lavm_isqrt import lavm_pkg::*; #(
    parameter int PW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [SUM_W-1:0] i_x,
    input  logic [PW-1:0]    i_pld,
    output logic             o_vld,
    output logic [LEN_W-1:0] o_root,
    output logic [PW-1:0]    o_pld
);
    localparam int STEPS  = LEN_W;
    localparam int PER    = 4;
    localparam int STAGES = (STEPS + PER - 1) / PER;
    localparam int REM_W  = LEN_W + 4;

    logic [STAGES:0]                 w_vld;
    logic [STAGES:0][REM_W-1:0]      w_rem;
    logic [STAGES:0][LEN_W-1:0]      w_root;
    logic [STAGES:0][SUM_W-1:0]      w_x;
    logic [STAGES:0][PW-1:0]         w_pld;

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_x[0]    = i_x;
    assign w_pld[0]  = i_pld;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic             r_vld;
        logic [REM_W-1:0] r_rem, n_rem;
        logic [LEN_W-1:0] r_root, n_root;
        logic [SUM_W-1:0] r_x, n_x;
        logic [PW-1:0]    r_pld;
        logic [REM_W-1:0] trial;

        always_comb begin
            n_rem  = w_rem[s];
            n_root = w_root[s];
            n_x    = w_x[s];
            trial  = '0;
            for (int k = 0; k < PER; k++) begin
                if (s * PER + k < STEPS) begin
                    n_rem = {n_rem[REM_W-3:0], n_x[SUM_W-1 -: 2]};
                    n_x   = n_x << 2;
                    trial = REM_W'({n_root, 2'b01});
                    if (n_rem >= trial) begin
                        n_rem  = n_rem - trial;
                        n_root = {n_root[LEN_W-2:0], 1'b1};
                    end else begin
                        n_root = {n_root[LEN_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_x    <= n_x;
                r_pld  <= w_pld[s];
            end
        end

        assign w_vld[s+1]  = r_vld;
        assign w_rem[s+1]  = r_rem;
        assign w_root[s+1] = r_root;
        assign w_x[s+1]    = r_x;
        assign w_pld[s+1]  = r_pld;
    end

    assign o_vld  = w_vld[STAGES];
    assign o_root = w_root[STAGES];
    assign o_pld  = w_pld[STAGES];

endmodule

// ===== rtl/lavm_div.sv =====
// Three-lane pipelined restoring divider: floor((m << FRAC_W) / len), m <= len.
module lavm_div import lavm_pkg::*; #(
    parameter int PW = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [LEN_W-1:0]         i_len,
    input  logic [2:0][NMAG_W-1:0]   i_m,
    input  logic [PW-1:0]            i_pld,
    output logic                     o_vld,
    output logic [2:0][Q_W-1:0]      o_q,
    output logic [PW-1:0]            o_pld
);
    localparam int STEPS  = Q_W;
    localparam int PER    = 3;
    localparam int STAGES = (STEPS + PER - 1) / PER;
    localparam int REM_W  = LEN_W + 1;

    logic [STAGES:0]                   w_vld;
    logic [STAGES:0][LEN_W-1:0]        w_len;
    logic [STAGES:0][2:0][REM_W-1:0]   w_rem;
    logic [STAGES:0][2:0][Q_W-1:0]     w_q;
    logic [STAGES:0][PW-1:0]           w_pld;

    assign w_vld[0] = i_vld;
    assign w_len[0] = i_len;
    assign w_pld[0] = i_pld;
    for (genvar l = 0; l < 3; l++) begin : g_init
        assign w_rem[0][l] = REM_W'(i_m[l]);
        assign w_q[0][l]   = '0;
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic                   r_vld;
        logic [LEN_W-1:0]       r_len;
        logic [2:0][REM_W-1:0]  r_rem, n_rem;
        logic [2:0][Q_W-1:0]    r_q, n_q;
        logic [PW-1:0]          r_pld;

        always_comb begin
            n_rem = w_rem[s];
            n_q   = w_q[s];
            for (int l = 0; l < 3; l++) begin
                for (int k = 0; k < PER; k++) begin
                    if (s * PER + k < STEPS) begin
                        // first step compares m itself, later ones shift in zeros
                        if (s * PER + k > 0) begin
                            n_rem[l] = n_rem[l] << 1;
                        end
                        if (n_rem[l] >= REM_W'(w_len[s])) begin
                            n_rem[l] = n_rem[l] - REM_W'(w_len[s]);
                            n_q[l]   = {n_q[l][Q_W-2:0], 1'b1};
                        end else begin
                            n_q[l]   = {n_q[l][Q_W-2:0], 1'b0};
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len <= w_len[s];
                r_rem <= n_rem;
                r_q   <= n_q;
                r_pld <= w_pld[s];
            end
        end

        assign w_vld[s+1] = r_vld;
        assign w_len[s+1] = r_len;
        assign w_rem[s+1] = r_rem;
        assign w_q[s+1]   = r_q;
        assign w_pld[s+1] = r_pld;
    end

    assign o_vld = w_vld[STAGES];
    assign o_q   = w_q[STAGES];
    assign o_pld = w_pld[STAGES];

endmodule

// ===== rtl/lavm_norm.sv =====
// Vector normalisation pipeline: range shift, sum of squares, root, divide, sign.
module lavm_norm import lavm_pkg::*; #(
    parameter int PW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_diff              i_v [3],
    input  logic [PW-1:0]      i_pld,
    output logic               o_vld,
    output t_unit              o_q [3],
    output logic               o_zero,
    output logic [PW-1:0]      o_pld
);
    localparam int SQ_PW  = 3 * NMAG_W + 3 + 1 + PW;
    localparam int DIV_PW = 3 + 1 + PW;

    // stage a: sign and magnitude
    logic                r_a_vld;
    logic [DIFF_W-1:0]   r_a_mag [3];
    logic [2:0]          r_a_neg;
    logic [DIFF_W-1:0]   r_a_or;
    logic [PW-1:0]       r_a_pld;

    // stage b: leading one position
    logic                r_b_vld;
    logic [DIFF_W-1:0]   r_b_mag [3];
    logic [2:0]          r_b_neg;
    logic [POS_W-1:0]    r_b_pos, n_b_pos;
    logic                r_b_zero;
    logic [PW-1:0]       r_b_pld;

    // stage c: common shift
    logic                r_c_vld;
    logic [NMAG_W-1:0]   r_c_m [3], n_c_m [3];
    logic [2:0]          r_c_neg;
    logic                r_c_zero;
    logic [PW-1:0]       r_c_pld;

    // stage d: squares
    logic                r_d_vld;
    logic [NMAG_W-1:0]   r_d_m [3];
    logic [SQR_W-1:0]    r_d_sq [3];
    logic [2:0]          r_d_neg;
    logic                r_d_zero;
    logic [PW-1:0]       r_d_pld;

    // stage e: sum
    logic                r_e_vld;
    logic [SUM_W-1:0]    r_e_sum;
    logic [SQ_PW-1:0]    r_e_pld;

    logic [POS_W-1:0]    sh;
    logic [SHL_W-1:0]    shl;

    always_comb begin
        n_b_pos = '0;
        for (int b = 0; b < DIFF_W; b++) begin
            if (r_a_or[b]) begin
                n_b_pos = POS_W'(b);
            end
        end
    end

    always_comb begin
        sh = '0;
        shl = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_b_pos > POS_W'(TARGET_MSB)) begin
                sh = r_b_pos - POS_W'(TARGET_MSB);
                n_c_m[i] = NMAG_W'(r_b_mag[i] >> sh);
            end else begin
                sh = POS_W'(TARGET_MSB) - r_b_pos;
                shl = SHL_W'(r_b_mag[i]) << sh;
                n_c_m[i] = shl[NMAG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_neg[i] <= i_v[i][DIFF_W-1];
                r_a_mag[i] <= i_v[i][DIFF_W-1] ? DIFF_W'(-i_v[i]) : DIFF_W'(i_v[i]);
            end
            r_a_or  <= (i_v[0][DIFF_W-1] ? DIFF_W'(-i_v[0]) : DIFF_W'(i_v[0]))
                     | (i_v[1][DIFF_W-1] ? DIFF_W'(-i_v[1]) : DIFF_W'(i_v[1]))
                     | (i_v[2][DIFF_W-1] ? DIFF_W'(-i_v[2]) : DIFF_W'(i_v[2]));
            r_a_pld <= i_pld;

            r_b_mag  <= r_a_mag;
            r_b_neg  <= r_a_neg;
            r_b_pos  <= n_b_pos;
            r_b_zero <= (r_a_or == '0);
            r_b_pld  <= r_a_pld;

            r_c_m    <= n_c_m;
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;
            r_c_pld  <= r_b_pld;

            for (int i = 0; i < 3; i++) begin
                r_d_sq[i] <= SQR_W'(r_c_m[i]) * SQR_W'(r_c_m[i]);
            end
            r_d_m    <= r_c_m;
            r_d_neg  <= r_c_neg;
            r_d_zero <= r_c_zero;
            r_d_pld  <= r_c_pld;

            r_e_sum <= SUM_W'(r_d_sq[0]) + SUM_W'(r_d_sq[1]) + SUM_W'(r_d_sq[2]);
            r_e_pld <= {r_d_m[0], r_d_m[1], r_d_m[2], r_d_neg, r_d_zero, r_d_pld};
        end
    end

    logic               sq_vld;
    logic [LEN_W-1:0]   sq_len;
    logic [SQ_PW-1:0]   sq_pld;

    lavm_isqrt #(.PW(SQ_PW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_e_vld),
        .i_x     (r_e_sum),
        .i_pld   (r_e_pld),
        .o_vld   (sq_vld),
        .o_root  (sq_len),
        .o_pld   (sq_pld)
    );

    logic [2:0][NMAG_W-1:0] dv_m;
    logic                   dv_vld;
    logic [2:0][Q_W-1:0]    dv_q;
    logic [DIV_PW-1:0]      dv_pld;

    assign dv_m[0] = sq_pld[SQ_PW-1 -: NMAG_W];
    assign dv_m[1] = sq_pld[SQ_PW-1-NMAG_W -: NMAG_W];
    assign dv_m[2] = sq_pld[SQ_PW-1-2*NMAG_W -: NMAG_W];

    lavm_div #(.PW(DIV_PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (sq_vld),
        .i_len   (sq_len),
        .i_m     (dv_m),
        .i_pld   (sq_pld[DIV_PW-1:0]),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_pld   (dv_pld)
    );

    // sign stage; neg bit of component i sits just above the zero flag, at PW+1+i
    logic              r_s_vld;
    t_unit             r_s_q [3];
    logic              r_s_zero;
    logic [PW-1:0]     r_s_pld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (i_en) begin
            r_s_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s_q[i] <= dv_pld[PW+1+i] ? -t_unit'({1'b0, dv_q[i]})
                                           : t_unit'({1'b0, dv_q[i]});
            end
            r_s_zero <= dv_pld[PW];
            r_s_pld  <= dv_pld[PW-1:0];
        end
    end

    assign o_vld  = r_s_vld;
    assign o_q    = r_s_q;
    assign o_zero = r_s_zero;
    assign o_pld  = r_s_pld;

endmodule

// ===== rtl/lavm_mat.sv =====
// True-up cross product and eye translations, four register stages.
module lavm_mat import lavm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_vld,
    input  t_unit   i_f [3],
    input  t_unit   i_r [3],
    input  t_coord  i_eye [3],
    input  logic    i_degen,
    output logic    o_vld,
    output t_unit   o_r [3],
    output t_up     o_u [3],
    output t_unit   o_f [3],
    output t_coord  o_t [3],
    output logic    o_degen
);
    localparam int PU_W = 2 * UNIT_W;
    localparam int PE_W = U_W + COORD_W;
    localparam int TD_W = PE_W + 4;
    localparam int UD_W = PU_W + 3;

    localparam logic signed [TD_W-1:0] C_MAX =
        {{(TD_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [TD_W-1:0] C_MIN = ~C_MAX;
    localparam logic signed [TD_W-1:0] T_HALF = TD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [UD_W-1:0] U_HALF = UD_W'(1) <<< (FRAC_W - 1);

    // -(a+b+c), rounded half up, clamped to the coordinate range
    function automatic t_coord neg_dot(input logic signed [PE_W-1:0] a,
                                       input logic signed [PE_W-1:0] b,
                                       input logic signed [PE_W-1:0] c);
        logic signed [TD_W-1:0] s;
        s = (T_HALF - (TD_W'(a) + TD_W'(b) + TD_W'(c))) >>> FRAC_W;
        if (s > C_MAX) begin
            return t_coord'(C_MAX);
        end else if (s < C_MIN) begin
            return t_coord'(C_MIN);
        end
        return t_coord'(s);
    endfunction

    // stage 1: products
    logic                     r1_vld;
    logic signed [PU_W-1:0]   r1_f1r2, r1_f2r0, r1_f0r2, r1_f1r0;
    logic signed [PE_W-1:0]   r1_re [3], r1_fe [3];
    t_unit                    r1_f [3], r1_r [3];
    t_coord                   r1_eye [3];
    logic                     r1_degen;

    // stage 2: true up, two translations
    logic                     r2_vld;
    t_up                      r2_u [3];
    t_coord                   r2_t0, r2_t2;
    t_unit                    r2_f [3], r2_r [3];
    t_coord                   r2_eye [3];
    logic                     r2_degen;

    // stage 3: up dot eye products
    logic                     r3_vld;
    logic signed [PE_W-1:0]   r3_ue [3];
    t_up                      r3_u [3];
    t_coord                   r3_t0, r3_t2;
    t_unit                    r3_f [3], r3_r [3];
    logic                     r3_degen;

    // stage 4: last translation
    logic                     r4_vld;
    t_up                      r4_u [3];
    t_coord                   r4_t [3];
    t_unit                    r4_f [3], r4_r [3];
    logic                     r4_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_f1r2 <= PU_W'(i_f[1]) * PU_W'(i_r[2]);
            r1_f2r0 <= PU_W'(i_f[2]) * PU_W'(i_r[0]);
            r1_f0r2 <= PU_W'(i_f[0]) * PU_W'(i_r[2]);
            r1_f1r0 <= PU_W'(i_f[1]) * PU_W'(i_r[0]);
            for (int i = 0; i < 3; i++) begin
                r1_re[i] <= PE_W'(i_r[i]) * PE_W'(i_eye[i]);
                r1_fe[i] <= PE_W'(i_f[i]) * PE_W'(i_eye[i]);
            end
            r1_f     <= i_f;
            r1_r     <= i_r;
            r1_eye   <= i_eye;
            r1_degen <= i_degen;

            r2_u[0]  <= U_W'((UD_W'(r1_f1r2) + U_HALF) >>> FRAC_W);
            r2_u[1]  <= U_W'((UD_W'(r1_f2r0) - UD_W'(r1_f0r2) + U_HALF) >>> FRAC_W);
            r2_u[2]  <= U_W'((U_HALF - UD_W'(r1_f1r0)) >>> FRAC_W);
            r2_t0    <= neg_dot(r1_re[0], r1_re[1], r1_re[2]);
            r2_t2    <= neg_dot(r1_fe[0], r1_fe[1], r1_fe[2]);
            r2_f     <= r1_f;
            r2_r     <= r1_r;
            r2_eye   <= r1_eye;
            r2_degen <= r1_degen;

            for (int i = 0; i < 3; i++) begin
                r3_ue[i] <= PE_W'(r2_u[i]) * PE_W'(r2_eye[i]);
            end
            r3_u     <= r2_u;
            r3_t0    <= r2_t0;
            r3_t2    <= r2_t2;
            r3_f     <= r2_f;
            r3_r     <= r2_r;
            r3_degen <= r2_degen;

            r4_t[0]  <= r3_t0;
            r4_t[1]  <= neg_dot(r3_ue[0], r3_ue[1], r3_ue[2]);
            r4_t[2]  <= r3_t2;
            r4_u     <= r3_u;
            r4_f     <= r3_f;
            r4_r     <= r3_r;
            r4_degen <= r3_degen;
        end
    end

    assign o_vld   = r4_vld;
    assign o_r     = r4_r;
    assign o_u     = r4_u;
    assign o_f     = r4_f;
    assign o_t     = r4_t;
    assign o_degen = r4_degen;

endmodule

// ===== rtl/look_at_view_matrix_top.sv =====
// Left-handed look-at view matrix builder, Q16.16, four row transactions per item.
//
//  channel  dir  transaction payload
//  i_in     in   eye_x/y/z, target_x/y/z
//  o_out    out  row_index, col0..col3, degenerate, last
//
// One item takes four row transactions: the row sender holds the finished matrix and
// the whole pipeline advances only when row 3 leaves or the sender holds no matrix,
// so no new item enters while a matrix waits. From acceptance to row 0 an item passes
// the input register, two normalise units of 20 stages each (square root at 4 bits a
// stage, divider at 3 bits a stage), four matrix stages and the row register.
// Reset is synchronous, active low, and clears only valid bits and the row counter.
// A stall on o_out freezes every stage together; nothing is dropped or repeated.
module look_at_view_matrix_top import lavm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lavm_in_if.sink        i_in,
    lavm_out_if.source     o_out
);
    `include "look_at_view_matrix_top_assert.svh"

    localparam int EYE_W = 3 * COORD_W;
    localparam int F_W   = 3 * UNIT_W;
    localparam int P2_W  = F_W + 1 + EYE_W;

    logic             en;
    logic             r_out_vld;
    logic [ROW_W-1:0] r_row;

    assign en = !r_out_vld || (o_out.ready && (r_row == ROW_LAST));
    assign i_in.ready = en;

    // input stage: exact differences
    logic          r0_vld;
    t_diff         r0_d [3];
    t_coord        r0_eye [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_d[0]   <= t_diff'(i_in.target_x) - t_diff'(i_in.eye_x);
            r0_d[1]   <= t_diff'(i_in.target_y) - t_diff'(i_in.eye_y);
            r0_d[2]   <= t_diff'(i_in.target_z) - t_diff'(i_in.eye_z);
            r0_eye[0] <= i_in.eye_x;
            r0_eye[1] <= i_in.eye_y;
            r0_eye[2] <= i_in.eye_z;
        end
    end

    // forward
    logic              n1_vld;
    t_unit             n1_f [3];
    logic              n1_zero;
    logic [EYE_W-1:0]  n1_pld;

    lavm_norm #(.PW(EYE_W)) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r0_vld),
        .i_v     (r0_d),
        .i_pld   ({r0_eye[0], r0_eye[1], r0_eye[2]}),
        .o_vld   (n1_vld),
        .o_q     (n1_f),
        .o_zero  (n1_zero),
        .o_pld   (n1_pld)
    );

    // right = normalise(fz, 0, -fx)
    t_diff             rv [3];
    logic              n2_vld;
    t_unit             n2_r [3];
    logic              n2_zero;
    logic [P2_W-1:0]   n2_pld;

    assign rv[0] = t_diff'(n1_f[2]);
    assign rv[1] = '0;
    assign rv[2] = -t_diff'(n1_f[0]);

    lavm_norm #(.PW(P2_W)) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (n1_vld),
        .i_v     (rv),
        .i_pld   ({n1_f[0], n1_f[1], n1_f[2], n1_zero, n1_pld}),
        .o_vld   (n2_vld),
        .o_q     (n2_r),
        .o_zero  (n2_zero),
        .o_pld   (n2_pld)
    );

    t_unit   m_f [3];
    t_coord  m_eye [3];

    assign m_f[0]   = n2_pld[P2_W-1 -: UNIT_W];
    assign m_f[1]   = n2_pld[P2_W-1-UNIT_W -: UNIT_W];
    assign m_f[2]   = n2_pld[P2_W-1-2*UNIT_W -: UNIT_W];
    assign m_eye[0] = n2_pld[EYE_W-1 -: COORD_W];
    assign m_eye[1] = n2_pld[EYE_W-1-COORD_W -: COORD_W];
    assign m_eye[2] = n2_pld[COORD_W-1:0];

    logic    mo_vld;
    t_unit   mo_r [3];
    t_up     mo_u [3];
    t_unit   mo_f [3];
    t_coord  mo_t [3];
    logic    mo_degen;

    lavm_mat u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (n2_vld),
        .i_f     (m_f),
        .i_r     (n2_r),
        .i_eye   (m_eye),
        .i_degen (n2_pld[EYE_W] | n2_zero),
        .o_vld   (mo_vld),
        .o_r     (mo_r),
        .o_u     (mo_u),
        .o_f     (mo_f),
        .o_t     (mo_t),
        .o_degen (mo_degen)
    );

    // row sender
    t_unit   r_r [3];
    t_up     r_u [3];
    t_unit   r_f [3];
    t_coord  r_t [3];
    logic    r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_row     <= '0;
        end else if (en) begin
            r_out_vld <= mo_vld;
            r_row     <= '0;
        end else if (o_out.ready) begin
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r     <= mo_r;
            r_u     <= mo_u;
            r_f     <= mo_f;
            r_t     <= mo_t;
            r_degen <= mo_degen;
        end
    end

    t_coord c0, c1, c2, c3;

    always_comb begin
        case (r_row)
            2'd0: begin
                c0 = t_coord'(r_r[0]);
                c1 = t_coord'(r_u[0]);
                c2 = t_coord'(r_f[0]);
                c3 = '0;
            end
            2'd1: begin
                c0 = t_coord'(r_r[1]);
                c1 = t_coord'(r_u[1]);
                c2 = t_coord'(r_f[1]);
                c3 = '0;
            end
            2'd2: begin
                c0 = t_coord'(r_r[2]);
                c1 = t_coord'(r_u[2]);
                c2 = t_coord'(r_f[2]);
                c3 = '0;
            end
            default: begin
                c0 = r_t[0];
                c1 = r_t[1];
                c2 = r_t[2];
                c3 = ONE_Q;
            end
        endcase
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.row_index  = r_row;
    assign o_out.col0       = r_degen ? '0 : c0;
    assign o_out.col1       = r_degen ? '0 : c1;
    assign o_out.col2       = r_degen ? '0 : c2;
    assign o_out.col3       = r_degen ? '0 : c3;
    assign o_out.degenerate = r_degen;
    assign o_out.last       = (r_row == ROW_LAST);

    `LAVM_ASSERT_NEXT(a_row_wraps, i_clk, i_rst_n,
        o_out.valid && o_out.ready && o_out.last, r_row == '0,
        "row counter did not restart after the last row")

    `LAVM_ASSERT_NEXT(a_row_steps, i_clk, i_rst_n,
        o_out.valid && o_out.ready && !o_out.last,
        o_out.valid && (r_row == $past(r_row) + 1'b1),
        "row counter did not advance after a row transaction")

    `LAVM_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n,
        o_out.valid && o_out.degenerate,
        o_out.col0 == '0 && o_out.col1 == '0 && o_out.col2 == '0 && o_out.col3 == '0,
        "degenerate row carries non-zero columns")

    `LAVM_ASSERT_NOW(a_unit_w, i_clk, i_rst_n,
        o_out.valid && !o_out.degenerate && o_out.last, o_out.col3 == ONE_Q,
        "translation row does not end in one")

endmodule

// ===== test/lavm_view_checker.sv =====
// Monitor of the look-at view matrix channels: predicts the four rows of each matrix and compares.
module lavm_view_checker import lavm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lavm_in_if     i_in,
    lavm_out_if    i_out,
    output int     o_fail_count,
    output int     o_rows_pending
);

    typedef struct {
        logic [ROW_W-1:0] row_index;
        t_coord           col [4];
        logic             degenerate;
        logic             last;
    } t_view_row;

    t_view_row rows_due [$];

    assign o_rows_pending = rows_due.size();

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Unit vector in Q16; returns 0 for a zero vector.
    function automatic bit make_unit(inout longint a, inout longint b, inout longint c);
        longint unsigned m [3];
        bit              n [3];
        longint unsigned mx, sum, len;
        longint          v [3];
        v = '{a, b, c};
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            n[i] = v[i] < 0;
            m[i] = n[i] ? longint'(-v[i]) : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            v[i] = longint'((m[i] << FRAC_W) / len);
            if (n[i]) v[i] = -v[i];
        end
        a = v[0];
        b = v[1];
        c = v[2];
        return 1;
    endfunction

    function automatic longint round_frac(longint v);
        return (v + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic longint clamp_coord(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (COORD_W - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    task automatic predict_view(input t_coord ex, ey, ez, tx, ty, tz);
        longint    e [3], f [3], r [3], u [3], t [3];
        longint    m [4][4];
        bit        degen;
        t_view_row row;
        e = '{longint'(ex), longint'(ey), longint'(ez)};
        f = '{longint'(tx) - e[0], longint'(ty) - e[1], longint'(tz) - e[2]};
        degen = !make_unit(f[0], f[1], f[2]);
        if (!degen) begin
            r = '{f[2], 0, -f[0]};
            degen = !make_unit(r[0], r[1], r[2]);
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) m[i][j] = 0;
        if (!degen) begin
            u[0] = round_frac(f[1] * r[2] - f[2] * r[1]);
            u[1] = round_frac(f[2] * r[0] - f[0] * r[2]);
            u[2] = round_frac(f[0] * r[1] - f[1] * r[0]);
            t[0] = clamp_coord(round_frac(-(r[0] * e[0] + r[1] * e[1] + r[2] * e[2])));
            t[1] = clamp_coord(round_frac(-(u[0] * e[0] + u[1] * e[1] + u[2] * e[2])));
            t[2] = clamp_coord(round_frac(-(f[0] * e[0] + f[1] * e[1] + f[2] * e[2])));
            for (int i = 0; i < 3; i++) begin
                m[i][0] = r[i];
                m[i][1] = u[i];
                m[i][2] = f[i];
                m[3][i] = t[i];
            end
            m[3][3] = longint'(ONE_Q);
        end
        for (int k = 0; k < 4; k++) begin
            row.row_index  = k[ROW_W-1:0];
            for (int j = 0; j < 4; j++) row.col[j] = t_coord'(m[k][j]);
            row.degenerate = degen;
            row.last       = (k[ROW_W-1:0] == ROW_LAST);
            rows_due.push_back(row);
        end
    endtask

    task automatic flag(input string what, input longint exp_v, input longint got_v);
        $display("%0t mismatch %s: expected %0d actual %0d", $time, what, exp_v, got_v);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_view_row want;
        t_coord    got [4];
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                predict_view(i_in.eye_x, i_in.eye_y, i_in.eye_z,
                             i_in.target_x, i_in.target_y, i_in.target_z);
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.col0, i_out.col1, i_out.col2, i_out.col3};
                if (rows_due.size() == 0) begin
                    $display("%0t unexpected row transaction, row_index %0d",
                             $time, i_out.row_index);
                    o_fail_count++;
                end else begin
                    want = rows_due.pop_front();
                    if (i_out.row_index !== want.row_index)
                        flag("row_index", want.row_index, i_out.row_index);
                    for (int j = 0; j < 4; j++)
                        if (got[j] !== want.col[j])
                            flag($sformatf("col%0d", j), want.col[j], got[j]);
                    if (i_out.degenerate !== want.degenerate)
                        flag("degenerate", want.degenerate, i_out.degenerate);
                    if (i_out.last !== want.last)
                        flag("last", want.last, i_out.last);
                end
            end
        end
    end

endmodule

// ===== test/look_at_view_matrix_top_tb.sv =====
// Stimulus and verdict for the look-at view matrix block.
module look_at_view_matrix_top_tb;
    import lavm_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   rows_pending;
    bit   steady;

    lavm_in_if  in_ch ();
    lavm_out_if out_ch ();

    look_at_view_matrix_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lavm_view_checker checker_u (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .o_fail_count   (fail_count),
        .o_rows_pending (rows_pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk)
        out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 38);

    task automatic send_view(input t_coord ex, ey, ez, tx, ty, tz);
        in_ch.valid    <= 1'b1;
        in_ch.eye_x    <= ex;
        in_ch.eye_y    <= ey;
        in_ch.eye_z    <= ez;
        in_ch.target_x <= tx;
        in_ch.target_y <= ty;
        in_ch.target_z <= tz;
        // ready is checked mid-cycle, the transaction completes at the next edge
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        while (!steady && $urandom_range(99) < 38) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic t_coord rand_coord(input int mode);
        case (mode)
            0:       return t_coord'($urandom);
            1:       return t_coord'($signed($urandom_range(2097152)) - 1048576);
            default: return t_coord'($signed($urandom_range(1024)) - 512);
        endcase
    endfunction

    localparam t_coord CMAX = 32'sh7fffffff;
    localparam t_coord CMIN = 32'sh80000000;

    initial begin
        t_coord ex, ey, ez;
        int     mode;
        i_rst_n        = 1'b0;
        steady         = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.eye_x    = '0;
        in_ch.eye_y    = '0;
        in_ch.eye_z    = '0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.target_z = '0;
        out_ch.ready   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero forward, straight up and down, near-vertical, extremes, saturation
        send_view(0, 0, 0, 0, 0, 0);
        send_view(CMAX, CMIN, 5, CMAX, CMIN, 5);
        send_view(0, 0, 0, 0, ONE_Q, 0);
        send_view(0, CMAX, 0, 0, CMIN, 0);
        send_view(1, 0, 0, 0, CMAX, 0);
        send_view(0, 0, 0, 0, 0, ONE_Q);
        send_view(0, 0, 0, ONE_Q, 0, 0);
        send_view(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_view(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
        send_view(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
        send_view(CMIN, CMAX, CMIN, 0, 0, 0);
        send_view(CMAX, CMAX, CMIN, CMAX - 1, CMAX, CMIN + 1);
        send_view(-1, -1, -1, 0, 0, 0);
        send_view(0, 0, 0, -1, 1, -1);
        send_view(32'sh00030000, 32'sh00020000, -32'sh00050000, 0, 0, 0);
        send_view(CMAX, 0, CMAX, 0, CMAX, 0);

        for (int n = 0; n < 350; n++) begin
            if (n == 120) begin
                // let the pipe drain completely before carrying on
                in_ch.valid <= 1'b0;
                while (rows_pending != 0) @(posedge i_clk);
            end
            steady = (n >= 200 && n < 250);
            mode = $urandom_range(2);
            ex = rand_coord(mode);
            ey = rand_coord(mode);
            ez = rand_coord(mode);
            case ($urandom_range(9))
                0:       send_view(ex, ey, ez, ex, ey, ez);
                1:       send_view(ex, ey, ez, ex, rand_coord(mode), ez);
                2:       send_view(ex, ey, ez, ex + t_coord'($urandom_range(3)),
                                   rand_coord(0), ez);
                default: send_view(ex, ey, ez, rand_coord(mode), rand_coord(mode),
                                   rand_coord(mode));
            endcase
        end
        in_ch.valid <= 1'b0;
        steady = 1'b0;
        while (rows_pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("[look_at_view_matrix_top] OK");
        else
            $display("[look_at_view_matrix_top] ERROR");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("[look_at_view_matrix_top] ERROR");
        $finish;
    end

endmodule
